// ===== design/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types and widths for the dfs topological sort core
// ----------------------------------------------------------------------------
`default_nettype none
package dfs_pkg;
  localparam int unsigned VtxW = 6;
  typedef logic [VtxW-1:0] vtx_t;
  typedef enum logic {
    FUNC_ADD     = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_e;
endpackage
`default_nettype wire

// ===== design/dfs_topological_sort_core.sv =====
// ----------------------------------------------------------------------------
// dfs_topological_sort_core
// depth-first topological sort with cycle detection over a stored edge list
// ----------------------------------------------------------------------------
// Edge beats (func 0) are taken one per cycle while the core is idle. A compute
// beat (func 1) starts a search that walks the edge memory through its single
// read port: every edge examined takes a read state then a check state, and
// each vertex adds a start pick, a final read and a frame restore. When the
// search ends, the finish list read is registered and out_ok_q is set before
// the first sorted vertex leaves; after each beat valid drops until out_ok_q
// is set again. The last beat is marked by tlast; a cycle gives one beat with
// vertex 0 and the cycle flag set. No new beat is taken until the run is
// delivered.
`default_nettype none
module dfs_topological_sort_core
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [5:0]  cfg_data_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // edge_from[5:0], edge_to[11:6], zero fill
  input  wire         s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // vertex[5:0], edges_dropped[6], zero fill
  output logic        m_axis_tuser_o,   // cycle_found
  output logic        m_axis_tlast_o
);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned SW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PICK = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   st_q, st_d;
  logic [5:0]   vcnt_q;
  logic [EW-1:0] nedge_q, nedge_d;
  logic         ovf_q, ovf_d;
  logic [MAX_VERTICES-1:0] vis_q, vis_d, ons_q, ons_d;
  logic [SW-1:0] sp_q, sp_d, fin_q, fin_d;
  vtx_t         start_q, start_d;
  logic         cyc_q, cyc_d;
  vtx_t         top_v_q, top_v_d;
  logic [EW-1:0] cur_q, cur_d;
  vtx_t         stk_v [MAX_VERTICES];
  logic [EW-1:0] stk_c [MAX_VERTICES];
  vtx_t         fin_mem [MAX_VERTICES];
  logic         stk_we, fin_we;
  logic [IW-1:0] stk_wa, fin_wa;
  vtx_t         stk_wv;
  logic [EW-1:0] stk_wc;
  logic [IW-1:0] stk_ra;
  vtx_t         stk_rv_q;
  logic [EW-1:0] stk_rc_q;
  logic [IW-1:0] fin_ra;
  vtx_t         fin_rd_q;
  logic         pop_pend_q, pop_pend_d;

  vtx_t         n_act;
  logic [6:0]   n_w;
  vtx_t         in_from, in_to;
  logic         s_fire, m_fire, e_we;
  vtx_t         e_src, e_dst;
  logic [AW-1:0] e_ra;
  logic         dropped_q, dropped_d;

  always_comb begin
    n_w = {1'b0, vcnt_q};
    if (vcnt_q == '0) n_w = 7'd1;
    if (n_w > 7'(MAX_VERTICES)) n_w = 7'(MAX_VERTICES);
    n_act = n_w[5:0];
  end

  assign in_from = s_axis_tdata_i[5:0];
  assign in_to   = s_axis_tdata_i[11:6];
  assign cfg_ready_o     = (st_q == ST_IDLE);
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o & m_axis_tready_i;
  assign e_we = s_fire && (s_axis_tuser_i == FUNC_ADD) && (in_from != '0) &&
                (in_from <= n_act) && (in_to != '0) && (in_to <= n_act) &&
                (nedge_q < EW'(MAX_EDGES));
  assign e_ra = cur_q[AW-1:0];

  dfs_edge_mem #(.Depth(MAX_EDGES), .AddrW(AW)) u_mem (
    .clk_i, .we_i(e_we), .waddr_i(nedge_q[AW-1:0]), .wsrc_i(in_from),
    .wdst_i(in_to), .raddr_i(e_ra), .rsrc_o(e_src), .rdst_o(e_dst)
  );

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_v[stk_wa] <= stk_wv;
      stk_c[stk_wa] <= stk_wc;
    end
    stk_rv_q <= stk_v[stk_ra];
    stk_rc_q <= stk_c[stk_ra];
    if (fin_we) fin_mem[fin_wa] <= top_v_q;
    fin_rd_q <= fin_mem[fin_ra];
  end

  // stack top frame kept in top_v_q/cur_q; stack array holds parent frames
  always_comb begin
    st_d = st_q; nedge_d = nedge_q; ovf_d = ovf_q; vis_d = vis_q; ons_d = ons_q;
    sp_d = sp_q; fin_d = fin_q; start_d = start_q; cyc_d = cyc_q;
    top_v_d = top_v_q; cur_d = cur_q; dropped_d = dropped_q;
    pop_pend_d = 1'b0;
    stk_we = 1'b0; stk_wa = sp_q[IW-1:0] - IW'(1); stk_wv = top_v_q; stk_wc = cur_q;
    stk_ra = sp_q[IW-1:0] - IW'(2);
    fin_we = 1'b0; fin_wa = fin_q[IW-1:0];
    fin_ra = fin_q[IW-1:0] - IW'(1);
    unique case (st_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == FUNC_COMPUTE) begin
            dropped_d = ovf_q; start_d = n_act; sp_d = '0; fin_d = '0;
            cyc_d = 1'b0; st_d = ST_PICK;
          end else if (e_we) begin
            nedge_d = nedge_q + EW'(1);
          end else if ((in_from != '0) && (in_from <= n_act) && (in_to != '0) &&
                       (in_to <= n_act)) begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_PICK: begin
        if (pop_pend_q) begin
          // restore parent frame read last cycle
          top_v_d = stk_rv_q;
          cur_d   = stk_rc_q;
          st_d = ST_RD;
        end else if (sp_q != '0) begin
          st_d = ST_RD;
        end else if (start_q == '0) begin
          st_d = ST_OUT;
        end else begin
          start_d = start_q - 6'd1;
          if (!vis_q[start_q[IW-1:0] - IW'(1)]) begin
            vis_d[start_q[IW-1:0] - IW'(1)] = 1'b1;
            ons_d[start_q[IW-1:0] - IW'(1)] = 1'b1;
            top_v_d = start_q; cur_d = '0; sp_d = SW'(1);
            st_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (cur_q < nedge_q) begin
          st_d = ST_CHK;
        end else begin
          ons_d[top_v_q[IW-1:0] - IW'(1)] = 1'b0;
          fin_we = 1'b1; fin_d = fin_q + SW'(1);
          sp_d = sp_q - SW'(1);
          pop_pend_d = (sp_q > SW'(1));
          st_d = ST_PICK;
        end
      end
      ST_CHK: begin
        cur_d = cur_q + EW'(1);
        st_d = ST_RD;
        if (e_src == top_v_q && e_dst != '0 && e_dst <= n_act) begin
          if (!vis_q[e_dst[IW-1:0] - IW'(1)]) begin
            if (sp_q < SW'(MAX_VERTICES)) begin
              stk_we = 1'b1; stk_wc = cur_q + EW'(1);
              vis_d[e_dst[IW-1:0] - IW'(1)] = 1'b1;
              ons_d[e_dst[IW-1:0] - IW'(1)] = 1'b1;
              top_v_d = e_dst; cur_d = '0; sp_d = sp_q + SW'(1);
            end
          end else if (ons_q[e_dst[IW-1:0] - IW'(1)]) begin
            cyc_d = 1'b1; st_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (m_fire) begin
          if (cyc_q || fin_q == SW'(1)) begin
            st_d = ST_IDLE; nedge_d = '0; ovf_d = 1'b0; vis_d = '0; ons_d = '0;
          end
          fin_d = fin_q - SW'(1);
          fin_ra = fin_q[IW-1:0] - IW'(2);
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // registered valid qualifier: set while ST_OUT holds with no beat taken, cleared by each beat
  logic out_ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; vcnt_q <= 6'd1; nedge_q <= '0; ovf_q <= 1'b0;
      vis_q <= '0; ons_q <= '0; sp_q <= '0; fin_q <= '0; cyc_q <= 1'b0;
      pop_pend_q <= 1'b0; out_ok_q <= 1'b0;
    end else begin
      st_q <= st_d; nedge_q <= nedge_d; ovf_q <= ovf_d; vis_q <= vis_d;
      ons_q <= ons_d; sp_q <= sp_d; fin_q <= fin_d; cyc_q <= cyc_d;
      pop_pend_q <= pop_pend_d;
      out_ok_q <= (st_d == ST_OUT) && (st_q == ST_OUT) && !m_fire;
      if (cfg_valid_i && cfg_ready_o) vcnt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; top_v_q <= top_v_d; cur_q <= cur_d; dropped_q <= dropped_d;
  end

  // output valid is held off on entering ST_OUT and after each beat until out_ok_q is set
  assign m_axis_tvalid_o = (st_q == ST_OUT) && out_ok_q;
  assign m_axis_tdata_o  = {1'b0, dropped_q, cyc_q ? 6'd0 : fin_rd_q};
  assign m_axis_tuser_o  = cyc_q;
  assign m_axis_tlast_o  = cyc_q || (fin_q == SW'(1));
endmodule
`default_nettype wire

// ===== design/dfs_edge_mem.sv =====
// ----------------------------------------------------------------------------
// dfs_edge_mem
// edge list memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module dfs_edge_mem
  import dfs_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire  clk_i,
  input  wire  we_i,
  input  wire  [AddrW-1:0] waddr_i,
  input  vtx_t wsrc_i,
  input  vtx_t wdst_i,
  input  wire  [AddrW-1:0] raddr_i,
  output vtx_t rsrc_o,
  output vtx_t rdst_o
);
  logic [2*VtxW-1:0] mem_q [Depth];
  logic [2*VtxW-1:0] rd_q;
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wdst_i, wsrc_i};
    end
    rd_q <= mem_q[raddr_i];
  end
  assign rsrc_o = rd_q[VtxW-1:0];
  assign rdst_o = rd_q[2*VtxW-1:VtxW];
endmodule
`default_nettype wire
